FILE: design/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned MaxW   = 16;
    localparam int unsigned CountW = 17;
    localparam int unsigned AccW   = 21;
    localparam int unsigned PendW  = 2;

    localparam logic [MaxW-1:0]   MaxBytesReset = 16'hFFFF;
    localparam logic [CountW-1:0] CountMax      = 17'h1FFFF;

    localparam logic [ByteW-1:0] NulByte   = 8'h00;
    localparam logic [ByteW-1:0] AsciiMax  = 8'h7F;
    localparam logic [ByteW-1:0] Lead2Min  = 8'hC2;
    localparam logic [ByteW-1:0] Lead2Max  = 8'hDF;
    localparam logic [ByteW-1:0] Lead3Min  = 8'hE0;
    localparam logic [ByteW-1:0] Lead3Max  = 8'hEF;
    localparam logic [ByteW-1:0] Lead4Min  = 8'hF0;
    localparam logic [ByteW-1:0] Lead4Max  = 8'hF4;
    localparam logic [1:0]       ContTag   = 2'b10;

    localparam logic [PendW-1:0] Class2 = 2'd1;
    localparam logic [PendW-1:0] Class3 = 2'd2;
    localparam logic [PendW-1:0] Class4 = 2'd3;

    localparam logic [AccW-1:0] Min2      = 21'h00080;
    localparam logic [AccW-1:0] Min3      = 21'h00800;
    localparam logic [AccW-1:0] Min4      = 21'h10000;
    localparam logic [AccW-1:0] CpMax     = 21'h10FFFF;
    localparam logic [AccW-1:0] SurrLow   = 21'h0D800;
    localparam logic [AccW-1:0] SurrHigh  = 21'h0DFFF;

    typedef struct packed {
        logic             last;
        logic [ByteW-1:0] data_byte;
        logic             has_byte;
    } t_item;

endpackage

FILE: design/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Streaming UTF-8 string checker with a configurable length limit.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one item per string byte. tdata carries the byte, tuser
//   says whether the item holds a byte, tlast marks the end of the string.
//   An item without a byte and without tlast is dropped; one with tlast
//   closes the string (alone it is the empty string, judged invalid).
//   Master channel: one item per string, on the item with tlast; bit 0 of
//   tdata is 1 when the string is well-formed UTF-8 within the length limit.
//   Config: i_cfg_wr_en writes i_cfg_wr_data as the maximum length in bytes;
//   write only while no string is in flight.
//   Throughput: one item per cycle while no closing item waits on a
//   pending result; the input register and the result register each take
//   one item a cycle, the decode step sits between them.
//   Reset: clears the string state, empties both registers, limit 65535.
//   Receiver stall: byte items keep flowing; a closing item waits in the
//   input register until the pending result is taken.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [utf8v_pkg::MaxW-1:0]  i_cfg_wr_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tuser,   // [0] has_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata    // [0] valid_res, [7:1] zero
);

    logic [utf8v_pkg::MaxW-1:0] r_max;
    logic                       r_in_valid;
    utf8v_pkg::t_item           r_in;
    logic                       r_out_valid;
    logic                       r_out_res;

    logic w_out_free;
    logic w_step;
    logic w_accept;
    logic w_res;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && (!r_in.last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= utf8v_pkg::MaxBytesReset;
        end else if (i_cfg_wr_en) begin
            r_max <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.has_byte  <= s_axis_tuser;
            r_in.data_byte <= s_axis_tdata;
            r_in.last      <= s_axis_tlast;
        end
    end

    utf8v_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (r_in),
        .i_max_bytes (r_max),
        .o_valid_res (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in.last) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_res};

endmodule

FILE: design/utf8v_core.sv
// ----------------------------------------------------------------------------
// utf8v_core
// Per-string decode state and next-state logic; gives the verdict of an item.
// ----------------------------------------------------------------------------
module utf8v_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  utf8v_pkg::t_item              i_item,
    input  logic [utf8v_pkg::MaxW-1:0]    i_max_bytes,
    output logic                          o_valid_res
);

    logic [utf8v_pkg::PendW-1:0]  r_pend,  n_pend;
    logic [utf8v_pkg::AccW-1:0]   r_acc,   n_acc;
    logic [utf8v_pkg::PendW-1:0]  r_cls,   n_cls;
    logic                         r_err,   n_err;
    logic [utf8v_pkg::CountW-1:0] r_cnt,   n_cnt;

    logic [utf8v_pkg::ByteW-1:0]  w_byte;
    logic [utf8v_pkg::AccW-1:0]   w_cp;
    logic [utf8v_pkg::AccW-1:0]   w_min;
    logic                         w_cp_bad;

    assign w_byte = i_item.data_byte;
    assign w_cp   = {r_acc[utf8v_pkg::AccW-7:0], w_byte[5:0]};

    always_comb begin
        unique case (r_cls)
            utf8v_pkg::Class2: w_min = utf8v_pkg::Min2;
            utf8v_pkg::Class3: w_min = utf8v_pkg::Min3;
            default:           w_min = utf8v_pkg::Min4;
        endcase
    end

    assign w_cp_bad = (w_cp < w_min) || (w_cp > utf8v_pkg::CpMax) ||
                      ((w_cp >= utf8v_pkg::SurrLow) && (w_cp <= utf8v_pkg::SurrHigh));

    always_comb begin
        n_pend = r_pend;
        n_acc  = r_acc;
        n_cls  = r_cls;
        n_err  = r_err;
        n_cnt  = r_cnt;
        if (i_item.has_byte) begin
            if (r_cnt != utf8v_pkg::CountMax) begin
                n_cnt = r_cnt + 17'd1;
            end
            if (w_byte == utf8v_pkg::NulByte) begin
                n_err  = 1'b1;
                n_pend = '0;
                n_acc  = '0;
                n_cls  = '0;
            end else if (!r_err) begin
                if (r_pend == '0) begin
                    priority if (w_byte <= utf8v_pkg::AsciiMax) begin
                        n_pend = '0;
                    end else if (w_byte >= utf8v_pkg::Lead2Min &&
                                 w_byte <= utf8v_pkg::Lead2Max) begin
                        n_pend = 2'd1;
                        n_cls  = utf8v_pkg::Class2;
                        n_acc  = {16'd0, w_byte[4:0]};
                    end else if (w_byte >= utf8v_pkg::Lead3Min &&
                                 w_byte <= utf8v_pkg::Lead3Max) begin
                        n_pend = 2'd2;
                        n_cls  = utf8v_pkg::Class3;
                        n_acc  = {17'd0, w_byte[3:0]};
                    end else if (w_byte >= utf8v_pkg::Lead4Min &&
                                 w_byte <= utf8v_pkg::Lead4Max) begin
                        n_pend = 2'd3;
                        n_cls  = utf8v_pkg::Class4;
                        n_acc  = {18'd0, w_byte[2:0]};
                    end else begin
                        n_err = 1'b1;
                    end
                end else if (w_byte[7:6] != utf8v_pkg::ContTag) begin
                    n_err  = 1'b1;
                    n_pend = '0;
                    n_acc  = '0;
                    n_cls  = '0;
                end else if (r_pend == 2'd1) begin
                    n_pend = '0;
                    n_acc  = '0;
                    n_cls  = '0;
                    n_err  = w_cp_bad;
                end else begin
                    n_pend = r_pend - 2'd1;
                    n_acc  = w_cp;
                end
            end
        end
    end

    assign o_valid_res = !n_err && (n_pend == '0) && (n_cnt != '0) &&
                         (n_cnt <= {1'b0, i_max_bytes});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_acc  <= '0;
            r_cls  <= '0;
            r_err  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_step) begin
            if (i_item.last) begin
                r_pend <= '0;
                r_acc  <= '0;
                r_cls  <= '0;
                r_err  <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_pend <= n_pend;
                r_acc  <= n_acc;
                r_cls  <= n_cls;
                r_err  <= n_err;
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule

FILE: tb/sv/tb_utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_validator
// Self-checking bench for the streaming UTF-8 string checker. A scoreboard
// class tracks the decode state of the string in flight and queues one
// verdict per closing item. Every verdict taken on the master side is
// compared against that queue. Stimulus runs in three parts. A directed part
// covers the code point bounds, overlong forms, surrogates, NUL bytes, empty
// strings and items without a byte. Random strings follow, mostly well-formed
// with some damage, under several length limits. Two strings sit just at and
// just beyond a length limit. Both sides idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
class verdict_board;
    bit [utf8v_pkg::MaxW-1:0]   max_len = utf8v_pkg::MaxBytesReset;
    bit [utf8v_pkg::PendW-1:0]  cont_due;
    bit [utf8v_pkg::AccW-1:0]   cp_acc;
    bit [utf8v_pkg::PendW-1:0]  seq_class;
    bit                         bad;
    bit [utf8v_pkg::CountW-1:0] n_bytes;
    bit                         verdicts_due[$];
    int unsigned                n_items;
    int unsigned                n_mismatch;

    function void flag_bad();
        bad       = 1'b1;
        cont_due  = '0;
        cp_acc    = '0;
        seq_class = '0;
    endfunction

    function void note_item(bit has_byte, bit [utf8v_pkg::ByteW-1:0] b, bit lst);
        bit [utf8v_pkg::AccW-1:0] floor_cp;
        if (has_byte || lst) begin
            n_items++;
        end
        if (has_byte) begin
            if (n_bytes != utf8v_pkg::CountMax) begin
                n_bytes++;
            end
            if (b == utf8v_pkg::NulByte) begin
                flag_bad();
            end
            if (!bad && cont_due == '0) begin
                if (b >= utf8v_pkg::Lead2Min && b <= utf8v_pkg::Lead2Max) begin
                    cont_due  = 2'd1;
                    seq_class = utf8v_pkg::Class2;
                    cp_acc    = {16'd0, b[4:0]};
                end else if (b >= utf8v_pkg::Lead3Min && b <= utf8v_pkg::Lead3Max) begin
                    cont_due  = 2'd2;
                    seq_class = utf8v_pkg::Class3;
                    cp_acc    = {17'd0, b[3:0]};
                end else if (b >= utf8v_pkg::Lead4Min && b <= utf8v_pkg::Lead4Max) begin
                    cont_due  = 2'd3;
                    seq_class = utf8v_pkg::Class4;
                    cp_acc    = {18'd0, b[2:0]};
                end else if (b > utf8v_pkg::AsciiMax) begin
                    flag_bad();
                end
            end else if (!bad) begin
                if (b[7:6] != utf8v_pkg::ContTag) begin
                    flag_bad();
                end else begin
                    cp_acc = {cp_acc[utf8v_pkg::AccW-7:0], b[5:0]};
                    cont_due--;
                    if (cont_due == '0) begin
                        case (seq_class)
                            utf8v_pkg::Class2: floor_cp = utf8v_pkg::Min2;
                            utf8v_pkg::Class3: floor_cp = utf8v_pkg::Min3;
                            default:           floor_cp = utf8v_pkg::Min4;
                        endcase
                        if (cp_acc < floor_cp || cp_acc > utf8v_pkg::CpMax ||
                            (cp_acc >= utf8v_pkg::SurrLow &&
                             cp_acc <= utf8v_pkg::SurrHigh)) begin
                            flag_bad();
                        end
                        cp_acc    = '0;
                        seq_class = '0;
                    end
                end
            end
        end
        if (lst) begin
            verdicts_due.insert(verdicts_due.size(),
                                !bad && cont_due == '0 && n_bytes != '0 &&
                                n_bytes <= {1'b0, max_len});
            cont_due  = '0;
            cp_acc    = '0;
            seq_class = '0;
            bad       = 1'b0;
            n_bytes   = '0;
        end
    endfunction

    function void check_verdict(logic [7:0] tdata);
        bit want;
        if (verdicts_due.size() == 0) begin
            $error("unexpected verdict item, tdata %02h", tdata);
            n_mismatch++;
        end else begin
            want = verdicts_due.pop_front();
            if (tdata[0] !== want) begin
                $error("valid_res mismatch: expected %0d, actual %0b", want, tdata[0]);
                n_mismatch++;
            end
            if (tdata[7:1] !== 7'd0) begin
                $error("tdata padding mismatch: expected 0, actual %02h", tdata[7:1]);
                n_mismatch++;
            end
        end
    endfunction
endclass

module tb_utf8_stream_validator;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [utf8v_pkg::MaxW-1:0] i_cfg_wr_data;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata;   // [7:0] data_byte
    logic                       s_axis_tuser;   // [0] has_byte
    logic                       s_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [7:0]                 m_axis_tdata;   // [0] valid_res, [7:1] zero

    verdict_board sb = new();
    bit calm;
    bit stall_req;

    utf8_stream_validator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_verdict(m_axis_tdata);
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                stall_req     = 1'b0;
                m_axis_tready = 1'b0;
                repeat (64) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    initial begin
        #(64'd20 * 64'd4_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic push_item(input bit has_byte, input logic [7:0] b, input bit lst);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = has_byte;
        s_axis_tdata  = b;
        s_axis_tlast  = lst;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(has_byte, b, lst);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.verdicts_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [utf8v_pkg::MaxW-1:0] v);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sb.max_len    = v;
    endtask

    task automatic send_ascii_run(input int unsigned len);
        int unsigned k;
        for (k = 0; k < len; k++) begin
            push_item(1'b1, 8'($urandom_range(1, 'h7F)), k == len - 1);
        end
    endtask

    task automatic send_random_string();
        logic [7:0]  bytes[$];
        logic [20:0] cp;
        int unsigned n_chars, n_len, k;
        bit          tail;
        n_chars = $urandom_range(0, 6);
        for (k = 0; k < n_chars; k++) begin
            case ($urandom_range(0, 3))
                0: begin
                    cp = 21'($urandom_range('h01, 'h7F));
                    n_len = 1;
                end
                1: begin
                    cp = 21'($urandom_range('h80, 'h7FF));
                    n_len = 2;
                end
                2: begin
                    cp = 21'($urandom_range('h800, 'hFFFF));
                    n_len = 3;
                end
                default: begin
                    cp = 21'($urandom_range('h10000, 'h10FFFF));
                    n_len = 4;
                end
            endcase
            if ($urandom_range(0, 15) == 0) begin
                cp    = 21'($urandom_range('h110000, 'h13FFFF));
                n_len = 4;
            end else if (n_len < 4 && $urandom_range(0, 15) == 0) begin
                n_len++;
            end
            case (n_len)
                1: bytes.insert(bytes.size(), cp[7:0]);
                2: begin
                    bytes.insert(bytes.size(), {3'b110, cp[10:6]});
                    bytes.insert(bytes.size(), {2'b10, cp[5:0]});
                end
                3: begin
                    bytes.insert(bytes.size(), {4'b1110, cp[15:12]});
                    bytes.insert(bytes.size(), {2'b10, cp[11:6]});
                    bytes.insert(bytes.size(), {2'b10, cp[5:0]});
                end
                default: begin
                    bytes.insert(bytes.size(), {5'b11110, cp[20:18]});
                    bytes.insert(bytes.size(), {2'b10, cp[17:12]});
                    bytes.insert(bytes.size(), {2'b10, cp[11:6]});
                    bytes.insert(bytes.size(), {2'b10, cp[5:0]});
                end
            endcase
        end
        if (bytes.size() != 0 && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom_range(0, 255));
                1: bytes.insert($urandom_range(0, bytes.size()), utf8v_pkg::NulByte);
                default: void'(bytes.pop_back());
            endcase
        end
        tail = bytes.size() == 0 || $urandom_range(0, 5) == 0;
        for (k = 0; k < bytes.size(); k++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item(1'b0, 8'($urandom), 1'b0);
            end
            push_item(1'b1, bytes[k], k == bytes.size() - 1 && !tail);
        end
        if (tail) begin
            push_item(1'b0, 8'($urandom), 1'b1);
        end
    endtask

    task automatic run_phase(input int unsigned n);
        int unsigned goal;
        goal = sb.n_items + n;
        while (sb.n_items < goal) send_random_string();
        drain();
    endtask

    initial begin
        int unsigned k;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        push_item(1'b0, 8'hA5, 1'b1);
        push_item(1'b1, 8'h7F, 1'b1);
        push_item(1'b0, 8'hFF, 1'b0);
        push_item(1'b1, 8'h00, 1'b1);
        push_item(1'b1, 8'hC2, 1'b0);
        push_item(1'b1, 8'h80, 1'b0);
        push_item(1'b0, 8'h5A, 1'b1);
        push_item(1'b1, 8'hF4, 1'b0);
        push_item(1'b1, 8'h8F, 1'b0);
        push_item(1'b1, 8'hBF, 1'b0);
        push_item(1'b1, 8'hBF, 1'b1);
        push_item(1'b1, 8'hF4, 1'b0);
        push_item(1'b1, 8'h90, 1'b0);
        push_item(1'b1, 8'h80, 1'b0);
        push_item(1'b1, 8'h80, 1'b1);
        push_item(1'b1, 8'hED, 1'b0);
        push_item(1'b1, 8'hA0, 1'b0);
        push_item(1'b1, 8'h80, 1'b1);
        push_item(1'b1, 8'hE0, 1'b0);
        push_item(1'b1, 8'h9F, 1'b0);
        push_item(1'b1, 8'hBF, 1'b1);
        push_item(1'b1, 8'hFF, 1'b0);
        push_item(1'b1, 8'h41, 1'b1);
        push_item(1'b1, 8'hE0, 1'b0);
        push_item(1'b1, 8'hA0, 1'b1);
        drain();

        set_limit(16'd1);
        run_phase(120);
        set_limit(16'd0);
        run_phase(40);
        set_limit(16'd40);
        send_ascii_run(40);
        send_ascii_run(41);
        drain();
        set_limit(16'hFFFF);

        // hold the result side while closing items keep coming
        stall_req = 1'b1;
        for (k = 0; k < 30; k++) begin
            push_item(1'b1, 8'h41, 1'b0);
            push_item(1'b1, 8'h42, 1'b1);
        end
        run_phase(90);

        set_limit(16'd3);
        run_phase(60);
        run_phase(60);
        set_limit(16'd16);
        run_phase(150);
        set_limit(16'($urandom_range(1, 'hFFFF)));
        run_phase(150);
        set_limit(16'd7);
        run_phase(150);

        calm = 1'b1;
        set_limit(16'd24);
        run_phase(180);

        repeat (8) @(negedge i_clk);
        if (sb.n_mismatch == 0 && sb.verdicts_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/utf8v_pkg.sv
design/utf8v_core.sv
design/utf8_stream_validator.sv
tb/sv/tb_utf8_stream_validator.sv
